### rtl/tslf_pkg.sv
// Package for the two-sensor line follower: shared types, register indexes,
// drive state codes and the microsecond to millisecond conversion.
// No dependencies.
`timescale 1ns / 1ps

package tslf_pkg;

  // Default width of the microsecond timestamp.
  localparam int DEF_TIME_BITS = 48;

  // Elapsed time that is kept for the millisecond conversion. A longer time
  // always saturates, since 65535 ms fit in fewer than 2**26 us.
  localparam int ELA_W = 26;
  localparam logic [ELA_W-1:0] MS_SAT_US = ELA_W'(65536 * 1000);

  // Divide by 1000 as a multiply by ceil(2**36 / 1000) and a shift by 36.
  // This is exact for every value below 2**26.
  localparam int RECIP_W = 27;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] MS_RECIP = RECIP_W'(68719477);

  localparam logic [9:0] US_PER_MS = 10'd1000;
  localparam logic [8:0] XING_SPD = 9'd120;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CRUISE_SPD       = 3'd0;
  localparam logic [2:0] CFG_NUDGE_SPD        = 3'd1;
  localparam logic [2:0] CFG_INNER_TRIM       = 3'd2;
  localparam logic [2:0] CFG_PIVOT_SPD        = 3'd3;
  localparam logic [2:0] CFG_CREEP_SPD        = 3'd4;
  localparam logic [2:0] CFG_CORNER_AFTER_MS  = 3'd5;
  localparam logic [2:0] CFG_RECOVER_MS       = 3'd6;
  localparam logic [2:0] CFG_PIVOT_TIMEOUT_MS = 3'd7;

  // Drive state codes on the result channel.
  localparam logic [2:0] DS_FORWARD      = 3'd0;
  localparam logic [2:0] DS_NUDGE_LEFT   = 3'd1;
  localparam logic [2:0] DS_NUDGE_RIGHT  = 3'd2;
  localparam logic [2:0] DS_CORNER_LEFT  = 3'd3;
  localparam logic [2:0] DS_CORNER_RIGHT = 3'd4;
  localparam logic [2:0] DS_RECOVER      = 3'd5;
  localparam logic [2:0] DS_LOST         = 3'd6;
  localparam logic [2:0] DS_JUNCTION     = 3'd7;

  // Tape side as a two-bit signed value.
  localparam logic [1:0] SIDE_NONE  = 2'b00;
  localparam logic [1:0] SIDE_RIGHT = 2'b01;
  localparam logic [1:0] SIDE_LEFT  = 2'b11;

  // Reset values of the registers; timeouts are held in microseconds.
  localparam logic [7:0] RST_CRUISE_SPD = 8'd165;
  localparam logic [7:0] RST_NUDGE_SPD  = 8'd135;
  localparam logic [7:0] RST_INNER_TRIM = 8'd95;
  localparam logic [7:0] RST_PIVOT_SPD  = 8'd150;
  localparam logic [7:0] RST_CREEP_SPD  = 8'd120;
  localparam logic [ELA_W-1:0] RST_CORNER_US  = ELA_W'(120 * 1000);
  localparam logic [ELA_W-1:0] RST_RECOVER_US = ELA_W'(260 * 1000);
  localparam logic [ELA_W-1:0] RST_PIVOT_US   = ELA_W'(2500 * 1000);

  typedef enum logic [4:0] {
    PH_FORWARD = 5'b00001,
    PH_NUDGE   = 5'b00010,
    PH_CORNER  = 5'b00100,
    PH_RECOVER = 5'b01000,
    PH_LOST    = 5'b10000
  } phase_t;

  // Configuration as seen by the decision logic.
  typedef struct packed {
    logic [7:0]       cruise_spd;
    logic [7:0]       nudge_spd;
    logic [7:0]       inner_trim;
    logic [7:0]       pivot_spd;
    logic [7:0]       creep_spd;
    logic [ELA_W-1:0] corner_us;
    logic [ELA_W-1:0] recover_us;
    logic [ELA_W-1:0] pivot_us;
  } cfg_t;

  // Decision result before the millisecond conversion.
  typedef struct packed {
    logic [8:0]       left_spd;
    logic [8:0]       right_spd;
    logic [2:0]       drive_state;
    logic [1:0]       turn_dir;
    logic [ELA_W-1:0] black_us;
    logic             black_sat;
  } mid_t;

  // Black time in milliseconds from the elapsed microseconds.
  function automatic logic [15:0] ms_from_us(input logic [ELA_W-1:0] us,
                                             input logic sat);
    logic [ELA_W+RECIP_W-1:0] prod;
    prod = (ELA_W + RECIP_W)'(us) * (ELA_W + RECIP_W)'(MS_RECIP);
    return sat ? 16'hFFFF : prod[RECIP_SHIFT+15:RECIP_SHIFT];
  endfunction

endpackage

### rtl/tslf_ctrl.sv
// Follower decision logic: phase machine, tape side and the three start
// timestamps, plus the wheel speeds and codes of one sample.
// Depends on tslf_pkg.
`timescale 1ns / 1ps

module tslf_ctrl #(
  parameter int TIME_BITS = tslf_pkg::DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 op,
  input  logic                 sense_left,
  input  logic                 sense_right,
  input  logic [TIME_BITS-1:0] now_us,
  input  tslf_pkg::cfg_t       cfg,
  output tslf_pkg::mid_t       res
);
  import tslf_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [1:0]           side_r, side_nxt;
  logic [TIME_BITS-1:0] black_since_r, black_since_nxt;
  logic [TIME_BITS-1:0] pivot_start_r, pivot_start_nxt;
  logic [TIME_BITS-1:0] recover_start_r, recover_start_nxt;
  logic                 black_set;
  logic                 junction;
  logic [1:0]           black;
  logic [TIME_BITS-1:0] ela_black, ela_pivot, ela_recover;
  logic [TIME_BITS-1:0] corner_lim, recover_lim, pivot_lim;
  logic [8:0]           nudge_inner;
  logic                 black_en;

  // Time since a start mark; a start in the future counts as no time.
  function automatic logic [TIME_BITS-1:0] elapsed(input logic [TIME_BITS-1:0] now,
                                                   input logic [TIME_BITS-1:0] since);
    logic [TIME_BITS:0] diff;
    diff = {1'b0, now} - {1'b0, since};
    return diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];
  endfunction

  assign junction = sense_left && sense_right;
  assign black    = sense_left ? SIDE_LEFT : (sense_right ? SIDE_RIGHT : SIDE_NONE);

  assign ela_black   = elapsed(now_us, black_since_r);
  assign ela_pivot   = elapsed(now_us, pivot_start_r);
  assign ela_recover = elapsed(now_us, recover_start_r);

  assign corner_lim  = TIME_BITS'(cfg.corner_us);
  assign recover_lim = TIME_BITS'(cfg.recover_us);
  assign pivot_lim   = TIME_BITS'(cfg.pivot_us);

  // Phase transitions on black-side changes and timeouts; a reset op or a junction clears all state to forward.
  always_comb begin
    phase_nxt         = phase_r;
    side_nxt          = side_r;
    black_since_nxt   = black_since_r;
    pivot_start_nxt   = pivot_start_r;
    recover_start_nxt = recover_start_r;
    black_set         = 1'b0;
    if (op || junction) begin
      phase_nxt         = PH_FORWARD;
      side_nxt          = SIDE_NONE;
      black_since_nxt   = '0;
      pivot_start_nxt   = '0;
      recover_start_nxt = '0;
    end else begin
      case (phase_r)
        PH_FORWARD: begin
          if (black != SIDE_NONE) begin
            phase_nxt       = PH_NUDGE;
            side_nxt        = black;
            black_since_nxt = now_us;
            black_set       = 1'b1;
          end
        end
        PH_NUDGE: begin
          if (black == SIDE_NONE) begin
            phase_nxt = PH_FORWARD;
            side_nxt  = SIDE_NONE;
          end else if (black != side_r) begin
            side_nxt        = black;
            black_since_nxt = now_us;
            black_set       = 1'b1;
          end else if (ela_black > corner_lim) begin
            phase_nxt       = PH_CORNER;
            pivot_start_nxt = now_us;
          end
        end
        PH_CORNER: begin
          if (black != SIDE_NONE && black != side_r) begin
            side_nxt        = black;
            pivot_start_nxt = now_us;
          end else if (black == SIDE_NONE) begin
            phase_nxt         = PH_RECOVER;
            recover_start_nxt = now_us;
          end else if (ela_pivot > pivot_lim) begin
            phase_nxt = PH_LOST;
          end
        end
        PH_RECOVER: begin
          if (black != SIDE_NONE) begin
            phase_nxt       = PH_CORNER;
            side_nxt        = black;
            pivot_start_nxt = now_us;
          end else if (ela_recover > recover_lim) begin
            phase_nxt = PH_FORWARD;
            side_nxt  = SIDE_NONE;
          end
        end
        default: begin
          // Lost stays until a reset op or a junction.
        end
      endcase
    end
  end

  // State registers advance once per processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_FORWARD;
      side_r          <= SIDE_NONE;
      black_since_r   <= '0;
      pivot_start_r   <= '0;
      recover_start_r <= '0;
    end else if (fire) begin
      phase_r         <= phase_nxt;
      side_r          <= side_nxt;
      black_since_r   <= black_since_nxt;
      pivot_start_r   <= pivot_start_nxt;
      recover_start_r <= recover_start_nxt;
    end
  end

  assign nudge_inner = {1'b0, cfg.nudge_spd} - {1'b0, cfg.inner_trim};

  // A freshly set black mark gives zero time, so the old mark's time is used
  // only when it was kept.
  assign black_en = (black != SIDE_NONE) && (black_since_r != '0) && !black_set;

  // Wheel speeds and codes from the new phase.
  always_comb begin
    res             = '0;
    res.black_us    = black_en ? ela_black[ELA_W-1:0] : '0;
    res.black_sat   = black_en && ((ela_black[TIME_BITS-1:ELA_W] != '0) ||
                                   (ela_black[ELA_W-1:0] >= MS_SAT_US));
    if (junction) begin
      res.left_spd    = XING_SPD;
      res.right_spd   = XING_SPD;
      res.drive_state = DS_JUNCTION;
      res.turn_dir    = SIDE_NONE;
      res.black_us    = '0;
      res.black_sat   = 1'b0;
    end else begin
      case (phase_nxt)
        PH_FORWARD: begin
          res.left_spd    = {1'b0, cfg.cruise_spd};
          res.right_spd   = {1'b0, cfg.cruise_spd};
          res.drive_state = DS_FORWARD;
        end
        PH_NUDGE: begin
          res.turn_dir = side_nxt;
          if (side_nxt == SIDE_LEFT) begin
            res.left_spd    = nudge_inner;
            res.right_spd   = {1'b0, cfg.nudge_spd};
            res.drive_state = DS_NUDGE_LEFT;
          end else begin
            res.left_spd    = {1'b0, cfg.nudge_spd};
            res.right_spd   = nudge_inner;
            res.drive_state = DS_NUDGE_RIGHT;
          end
        end
        PH_CORNER: begin
          res.turn_dir = side_nxt;
          if (side_nxt == SIDE_LEFT) begin
            res.left_spd    = 9'd0 - {1'b0, cfg.pivot_spd};
            res.right_spd   = {1'b0, cfg.pivot_spd};
            res.drive_state = DS_CORNER_LEFT;
          end else begin
            res.left_spd    = {1'b0, cfg.pivot_spd};
            res.right_spd   = 9'd0 - {1'b0, cfg.pivot_spd};
            res.drive_state = DS_CORNER_RIGHT;
          end
        end
        PH_RECOVER: begin
          res.left_spd    = {1'b0, cfg.creep_spd};
          res.right_spd   = {1'b0, cfg.creep_spd};
          res.drive_state = DS_RECOVER;
        end
        default: begin
          res.left_spd    = '0;
          res.right_spd   = '0;
          res.drive_state = DS_LOST;
        end
      endcase
    end
  end

endmodule

### rtl/two_sensor_line_follower_fsm_top.sv
// Top level of the two-sensor line follower: configuration registers, the
// three-stage beat pipeline and the millisecond conversion.
// Depends on tslf_pkg and tslf_ctrl.
`timescale 1ns / 1ps

// The follower takes one sensor beat per clock with no gap between beats
// while in_stall is low, and presents its drive result once the beat has
// passed the input register, the decision stage that updates the phase
// machine, and the output register that is loaded with the black time
// turned into milliseconds. A reset op clears the follower state in the
// decision stage and produces no result. Each stage holds its beat only
// while the stage after it is full and stalled, so bubbles are absorbed;
// while a finished result waits on out_stall, up to two more input beats
// are still taken before in_stall rises. Configuration is written on the
// plain write port and takes effect for every beat decided after the write.
module two_sensor_line_follower_fsm_top #(
  parameter int TIME_BITS = tslf_pkg::DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  // Sensor beats
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic                 in_sense_left,
  input  logic                 in_sense_right,
  input  logic [TIME_BITS-1:0] in_now_us,
  // Drive results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [8:0]    out_left_spd,
  output logic signed [8:0]    out_right_spd,
  output logic [2:0]           out_drive_state,
  output logic signed [1:0]    out_turn_dir,
  output logic [15:0]          out_dark_ms
);
  import tslf_pkg::*;

  cfg_t                 cfg_r;
  logic [ELA_W-1:0]     cfg_us;

  logic                 s0_valid_r;
  logic                 s0_op_r, s0_left_r, s0_right_r;
  logic [TIME_BITS-1:0] s0_now_r;
  logic                 s1_valid_r;
  mid_t                 s1_r;
  mid_t                 mid;
  logic                 out_valid_r;
  logic [8:0]           out_left_r, out_right_r;
  logic [2:0]           out_state_r;
  logic [1:0]           out_dir_r;
  logic [15:0]          out_ms_r;

  logic                 s2_free, s1_free, s0_free, s0_fire;

  // Timeouts are stored in microseconds.
  assign cfg_us = ELA_W'(cfg_data) * ELA_W'(US_PER_MS);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cruise_spd <= RST_CRUISE_SPD;
      cfg_r.nudge_spd  <= RST_NUDGE_SPD;
      cfg_r.inner_trim <= RST_INNER_TRIM;
      cfg_r.pivot_spd  <= RST_PIVOT_SPD;
      cfg_r.creep_spd  <= RST_CREEP_SPD;
      cfg_r.corner_us  <= RST_CORNER_US;
      cfg_r.recover_us <= RST_RECOVER_US;
      cfg_r.pivot_us   <= RST_PIVOT_US;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRUISE_SPD:       cfg_r.cruise_spd <= cfg_data[7:0];
        CFG_NUDGE_SPD:        cfg_r.nudge_spd  <= cfg_data[7:0];
        CFG_INNER_TRIM:       cfg_r.inner_trim <= cfg_data[7:0];
        CFG_PIVOT_SPD:        cfg_r.pivot_spd  <= cfg_data[7:0];
        CFG_CREEP_SPD:        cfg_r.creep_spd  <= cfg_data[7:0];
        CFG_CORNER_AFTER_MS:  cfg_r.corner_us  <= cfg_us;
        CFG_RECOVER_MS:       cfg_r.recover_us <= cfg_us;
        CFG_PIVOT_TIMEOUT_MS: cfg_r.pivot_us   <= cfg_us;
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow: a stage moves on when the next one is empty or moving.
  assign s2_free  = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || s2_free;
  assign s0_free  = !s0_valid_r || s1_free;
  assign s0_fire  = s0_valid_r && s1_free;
  assign in_stall = !s0_free;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s0_free) s0_valid_r <= in_valid;
      if (s1_free) s1_valid_r <= s0_valid_r && !s0_op_r;
      if (s2_free) out_valid_r <= s1_valid_r;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_valid && s0_free) begin
      s0_op_r    <= in_op;
      s0_left_r  <= in_sense_left;
      s0_right_r <= in_sense_right;
      s0_now_r   <= in_now_us;
    end
  end

  // Decision stage.
  tslf_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s0_fire),
    .op          (s0_op_r),
    .sense_left  (s0_left_r),
    .sense_right (s0_right_r),
    .now_us      (s0_now_r),
    .cfg         (cfg_r),
    .res         (mid)
  );

  always_ff @(posedge clk) begin
    if (s0_fire) s1_r <= mid;
  end

  // Output register with the millisecond conversion.
  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_free) begin
      out_left_r  <= s1_r.left_spd;
      out_right_r <= s1_r.right_spd;
      out_state_r <= s1_r.drive_state;
      out_dir_r   <= s1_r.turn_dir;
      out_ms_r    <= ms_from_us(s1_r.black_us, s1_r.black_sat);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_spd    = out_left_r;
  assign out_right_spd   = out_right_r;
  assign out_drive_state = out_state_r;
  assign out_turn_dir    = out_dir_r;
  assign out_dark_ms     = out_ms_r;

endmodule

### rtl/tslf_checker.sv
// Port-level checks for the two-sensor line follower result channel,
// bound to the top level.
// Depends on tslf_pkg and two_sensor_line_follower_fsm_top.
`timescale 1ns / 1ps

module tslf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [8:0] out_left_spd,
  input logic signed [8:0] out_right_spd,
  input logic [2:0]        out_drive_state,
  input logic signed [1:0] out_turn_dir,
  input logic [15:0]       out_dark_ms
);
  import tslf_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_spd) &&
      $stable(out_right_spd) && $stable(out_drive_state) &&
      $stable(out_turn_dir) && $stable(out_dark_ms))
    else $error("result beat changed while stalled");

  // A junction crosses straight at the fixed speed with no black time.
  a_junction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_state == DS_JUNCTION |->
      out_left_spd == 9'sd120 && out_right_spd == 9'sd120 &&
      out_turn_dir == 2'sd0 && out_dark_ms == 16'd0)
    else $error("junction result is wrong");

  // A lost line stops both wheels.
  a_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_state == DS_LOST |->
      out_left_spd == 9'sd0 && out_right_spd == 9'sd0 && out_turn_dir == 2'sd0)
    else $error("lost result is wrong");

  // A turn direction only goes with a nudge or a corner.
  a_turn_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_turn_dir != 2'sd0 |->
      (out_drive_state == DS_NUDGE_LEFT || out_drive_state == DS_NUDGE_RIGHT ||
       out_drive_state == DS_CORNER_LEFT || out_drive_state == DS_CORNER_RIGHT))
    else $error("turn direction outside nudge or corner");

  // Straight drive states run both wheels at the same speed.
  a_straight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_drive_state == DS_FORWARD || out_drive_state == DS_RECOVER) |->
      out_left_spd == out_right_spd)
    else $error("wheel speeds differ in straight drive");

endmodule

bind two_sensor_line_follower_fsm_top tslf_checker u_tslf_checker (.*);

### tb/line_follower_checker.sv
// Drive checker for the two-sensor line follower: watches the config port and
// both beat channels, predicts each drive result and compares it field by field.
// Depends on tslf_pkg.
`timescale 1ns / 1ps

module line_follower_checker #(
  parameter int TW = tslf_pkg::DEF_TIME_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_op,
  input  logic                in_sense_left,
  input  logic                in_sense_right,
  input  logic [TW-1:0]       in_now_us,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [8:0]   out_left_spd,
  input  logic signed [8:0]   out_right_spd,
  input  logic [2:0]          out_drive_state,
  input  logic signed [1:0]   out_turn_dir,
  input  logic [15:0]         out_dark_ms,
  output int                  errors,
  output int                  pending,
  output int                  checked
);
  import tslf_pkg::*;

  typedef struct packed {
    logic signed [8:0] lspd;
    logic signed [8:0] rspd;
    logic [2:0]        code;
    logic signed [1:0] dir;
    logic [15:0]       ms;
  } drive_t;

  // Local copy of the registers.
  logic [7:0]  cruise_spd, nudge_spd, trim, pivot_spd, creep_spd;
  logic [15:0] corner_ms, creep_ms, pivot_ms;

  // Local copy of the follower state.
  phase_t        phase;
  logic [1:0]    side;
  logic [TW-1:0] black_t0, pivot_t0, creep_t0;

  // Drive results still owed by the block, oldest first.
  drive_t owed_q[$];

  function automatic void load_defaults();
    cruise_spd = RST_CRUISE_SPD;
    nudge_spd  = RST_NUDGE_SPD;
    trim       = RST_INNER_TRIM;
    pivot_spd  = RST_PIVOT_SPD;
    creep_spd  = RST_CREEP_SPD;
    corner_ms  = 16'd120;
    creep_ms   = 16'd260;
    pivot_ms   = 16'd2500;
  endfunction

  function automatic void clear_follow();
    phase    = PH_FORWARD;
    side     = SIDE_NONE;
    black_t0 = '0;
    pivot_t0 = '0;
    creep_t0 = '0;
  endfunction

  // Elapsed time; a timestamp behind the start counts as no time at all.
  function automatic logic [TW-1:0] span(input logic [TW-1:0] now, input logic [TW-1:0] since);
    return (now >= since) ? now - since : '0;
  endfunction

  // A timeout fires only once the elapsed time is strictly beyond the limit.
  function automatic bit expired(input logic [TW-1:0] now, input logic [TW-1:0] since,
                                 input logic [15:0] ms);
    return 64'(span(now, since)) > 64'(ms) * 64'(US_PER_MS);
  endfunction

  // One sensor sample: step the phase machine and form the drive result.
  function automatic drive_t follow_step(input logic l, input logic r,
                                         input logic [TW-1:0] now);
    logic [1:0]  black;
    logic [63:0] ms_long;
    int          ls, rs;
    drive_t      d;
    // Both sensors black is a crossing line: start over and cross at the fixed crossing speed.
    if (l && r) begin
      clear_follow();
      d.lspd = XING_SPD;
      d.rspd = XING_SPD;
      d.code = DS_JUNCTION;
      d.dir  = SIDE_NONE;
      d.ms   = '0;
      return d;
    end
    // The left sensor is tested first.
    black = l ? SIDE_LEFT : (r ? SIDE_RIGHT : SIDE_NONE);
    case (phase)
      PH_FORWARD: begin
        if (black != SIDE_NONE) begin
          phase    = PH_NUDGE;
          side     = black;
          black_t0 = now;
        end
      end
      PH_NUDGE: begin
        if (black == SIDE_NONE) begin
          phase = PH_FORWARD;
          side  = SIDE_NONE;
        end else if (black != side) begin
          side     = black;
          black_t0 = now;
        end else if (expired(now, black_t0, corner_ms)) begin
          phase    = PH_CORNER;
          pivot_t0 = now;
        end
      end
      PH_CORNER: begin
        if (black != SIDE_NONE && black != side) begin
          side     = black;
          pivot_t0 = now;
        end else if (black == SIDE_NONE) begin
          phase    = PH_RECOVER;
          creep_t0 = now;
        end else if (expired(now, pivot_t0, pivot_ms)) begin
          phase = PH_LOST;
        end
      end
      PH_RECOVER: begin
        if (black != SIDE_NONE) begin
          phase    = PH_CORNER;
          side     = black;
          pivot_t0 = now;
        end else if (expired(now, creep_t0, creep_ms)) begin
          phase = PH_FORWARD;
          side  = SIDE_NONE;
        end
      end
      default: ;
    endcase

    d.dir = (phase == PH_NUDGE || phase == PH_CORNER) ? side : SIDE_NONE;
    // A zero start time means the black time was never set.
    d.ms = '0;
    if (black != SIDE_NONE && black_t0 != '0) begin
      ms_long = 64'(span(now, black_t0)) / 64'(US_PER_MS);
      d.ms = (ms_long > 64'hFFFF) ? 16'hFFFF : ms_long[15:0];
    end

    case (phase)
      PH_FORWARD: begin
        ls = int'(cruise_spd);
        rs = int'(cruise_spd);
        d.code = DS_FORWARD;
      end
      PH_NUDGE: begin
        if (side == SIDE_LEFT) begin
          ls = int'(nudge_spd) - int'(trim);
          rs = int'(nudge_spd);
          d.code = DS_NUDGE_LEFT;
        end else begin
          ls = int'(nudge_spd);
          rs = int'(nudge_spd) - int'(trim);
          d.code = DS_NUDGE_RIGHT;
        end
      end
      PH_CORNER: begin
        if (side == SIDE_LEFT) begin
          ls = -int'(pivot_spd);
          rs = int'(pivot_spd);
          d.code = DS_CORNER_LEFT;
        end else begin
          ls = int'(pivot_spd);
          rs = -int'(pivot_spd);
          d.code = DS_CORNER_RIGHT;
        end
      end
      PH_RECOVER: begin
        ls = int'(creep_spd);
        rs = int'(creep_spd);
        d.code = DS_RECOVER;
      end
      default: begin
        ls = 0;
        rs = 0;
        d.code = DS_LOST;
      end
    endcase
    d.lspd = 9'(ls);
    d.rspd = 9'(rs);
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] drive check: %s", $time, msg);
  endtask

  // Results leave before new beats enter: a result never belongs to a beat
  // taken at the same edge.
  always @(posedge clk) begin
    drive_t want;
    if (!rst_n) begin
      load_defaults();
      clear_follow();
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CRUISE_SPD:       cruise_spd = cfg_data[7:0];
          CFG_NUDGE_SPD:        nudge_spd  = cfg_data[7:0];
          CFG_INNER_TRIM:       trim       = cfg_data[7:0];
          CFG_PIVOT_SPD:        pivot_spd  = cfg_data[7:0];
          CFG_CREEP_SPD:        creep_spd  = cfg_data[7:0];
          CFG_CORNER_AFTER_MS:  corner_ms  = cfg_data;
          CFG_RECOVER_MS:       creep_ms   = cfg_data;
          CFG_PIVOT_TIMEOUT_MS: pivot_ms   = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          report_mismatch($sformatf("drive result (state %0d) with none expected",
                                    out_drive_state));
        end else begin
          want = owed_q.pop_front();
          checked++;
          if (out_left_spd !== want.lspd)
            report_mismatch($sformatf("result %0d left_spd %0d, expected %0d",
                                      checked, out_left_spd, want.lspd));
          if (out_right_spd !== want.rspd)
            report_mismatch($sformatf("result %0d right_spd %0d, expected %0d",
                                      checked, out_right_spd, want.rspd));
          if (out_drive_state !== want.code)
            report_mismatch($sformatf("result %0d drive_state %0d, expected %0d",
                                      checked, out_drive_state, want.code));
          if (out_turn_dir !== want.dir)
            report_mismatch($sformatf("result %0d turn_dir %0d, expected %0d",
                                      checked, out_turn_dir, want.dir));
          if (out_dark_ms !== want.ms)
            report_mismatch($sformatf("result %0d dark_ms %0d, expected %0d",
                                      checked, out_dark_ms, want.ms));
        end
      end

      // A reset op clears the follower and owes nothing.
      if (in_valid && !in_stall) begin
        if (in_op) clear_follow();
        else owed_q.push_back(follow_step(in_sense_left, in_sense_right, in_now_us));
      end
    end
    pending <= owed_q.size();
  end

endmodule

### tb/tb_two_sensor_line_follower_fsm_top.sv
// Testbench top for the two-sensor line follower: clock, reset, beat stimulus,
// register settings, random stalls, watchdog and verdict.
// Depends on tslf_pkg, two_sensor_line_follower_fsm_top and line_follower_checker.
`timescale 1ns / 1ps

module tb_two_sensor_line_follower_fsm_top;
  import tslf_pkg::*;

  localparam int TW                = DEF_TIME_BITS;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int NUM_SETTINGS      = 8;
  localparam int BEATS_PER_SETTING = 178;
  localparam bit OP_SAMPLE         = 1'b0;
  localparam bit OP_RESET          = 1'b1;

  typedef enum logic [1:0] {TAPE_CLEAR, TAPE_LEFT, TAPE_RIGHT} tape_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [2:0]           cfg_index      = '0;
  logic [15:0]          cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_op          = 1'b0;
  logic                 in_sense_left  = 1'b0;
  logic                 in_sense_right = 1'b0;
  logic [TW-1:0]        in_now_us      = '0;
  logic                 out_stall      = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic signed [8:0]    out_left_spd;
  logic signed [8:0]    out_right_spd;
  logic [2:0]           out_drive_state;
  logic signed [1:0]    out_turn_dir;
  logic [15:0]          out_dark_ms;

  int errors, pending, checked;

  bit            idle_on    = 1'b0;
  int            stall_left = 0;
  int            quiet      = 0;
  int            beats      = 0;
  logic [TW-1:0] sim_us     = '0;
  tape_t         tape       = TAPE_CLEAR;

  two_sensor_line_follower_fsm_top uut (.*);

  line_follower_checker #(.TW(TW)) drive_chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver side: stall in random bursts while idling is on.
  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(0, 18);
    end
  end

  // Watchdog: too long without any beat moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Present one beat, after an optional gap, and hold it until it is taken.
  task automatic send_beat(input bit op, input bit l, input bit r, input logic [TW-1:0] t);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_sense_left  <= l;
    in_sense_right <= r;
    in_now_us      <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats++;
  endtask

  // Stop sending and let every owed result and the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Keeps cfg_we high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // The upper byte of the 8-bit registers carries junk that must be dropped.
  task automatic apply_settings(input logic [7:0] cs, input logic [7:0] ns,
                                input logic [7:0] nt, input logic [7:0] ps,
                                input logic [7:0] rs, input logic [15:0] ca,
                                input logic [15:0] rm, input logic [15:0] pt);
    write_reg(CFG_CRUISE_SPD,       {8'($urandom), cs});
    write_reg(CFG_NUDGE_SPD,        {8'($urandom), ns});
    write_reg(CFG_INNER_TRIM,       {8'($urandom), nt});
    write_reg(CFG_PIVOT_SPD,        {8'($urandom), ps});
    write_reg(CFG_CREEP_SPD,        {8'($urandom), rs});
    write_reg(CFG_CORNER_AFTER_MS,  ca);
    write_reg(CFG_RECOVER_MS,       rm);
    write_reg(CFG_PIVOT_TIMEOUT_MS, pt);
    cfg_we <= 1'b0;
  endtask

  // Mostly tape excursions on a moving clock, with some junctions, reset ops,
  // odd time jumps and fully random noise beats mixed in.
  task automatic random_beats(input int n, input bit busy);
    logic [63:0] wide;
    int          pick, step;
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 0) idle_on = busy && ($urandom_range(0, 3) != 0);
      wide = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_beat($urandom_range(0, 7) == 0, 1'($urandom), 1'($urandom),
                  pick < 3 ? TW'(0) : (pick < 6 ? TW'(wide) : sim_us));
      end else begin
        step = $urandom_range(0, 99);
        if (step < 65)      sim_us += TW'($urandom_range(0, 40_000));
        else if (step < 88) sim_us += TW'($urandom_range(0, 400_000));
        else if (step < 96) sim_us += TW'($urandom_range(0, 3_000_000));
        else if (step < 98) sim_us -= TW'($urandom_range(0, 50_000));
        else                sim_us += TW'(wide[31:0]) * TW'(1000);
        if ($urandom_range(0, 4) == 0) tape = tape_t'($urandom_range(0, 2));
        if (pick < 11)
          send_beat(OP_RESET, 1'($urandom), 1'($urandom), sim_us);
        else if (pick < 16)
          send_beat(OP_SAMPLE, 1'b1, 1'b1, sim_us);
        else
          send_beat(OP_SAMPLE, tape == TAPE_LEFT, tape == TAPE_RIGHT, sim_us);
      end
    end
  endtask

  initial begin
    logic [7:0]  cs, ns, nt, ps, rs;
    logic [15:0] ca, rm, pt;
    int          directed;
    repeat (5) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on <= 1'b1;

    // Directed walk through every phase with the reset-value registers.
    send_beat(OP_RESET,  1'b1, 1'b1, 48'd12345);       // reset op ignores sensors
    send_beat(OP_SAMPLE, 1'b0, 1'b0, 48'd0);
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 48'd0);           // black time left unset
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 48'd200000);      // corner from an unset start
    send_beat(OP_SAMPLE, 1'b1, 1'b1, 48'd200500);      // junction
    send_beat(OP_SAMPLE, 1'b0, 1'b1, 48'd1000);
    send_beat(OP_SAMPLE, 1'b0, 1'b1, 48'd5000);
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 48'd6000);        // side swap in nudge
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 48'd126000);      // exactly at the limit
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 48'd126001);      // just past it: corner
    send_beat(OP_SAMPLE, 1'b0, 1'b1, 48'd130000);      // side swap in corner
    send_beat(OP_SAMPLE, 1'b0, 1'b0, 48'd140000);      // recover
    send_beat(OP_SAMPLE, 1'b0, 1'b0, 48'd400000);
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 48'd401000);      // back to corner
    send_beat(OP_SAMPLE, 1'b0, 1'b0, 48'd402000);
    send_beat(OP_SAMPLE, 1'b0, 1'b0, 48'd662001);      // recover times out
    send_beat(OP_SAMPLE, 1'b0, 1'b1, 48'd700000);
    send_beat(OP_SAMPLE, 1'b0, 1'b1, 48'd900000);
    send_beat(OP_SAMPLE, 1'b0, 1'b1, 48'd3400000);
    send_beat(OP_SAMPLE, 1'b0, 1'b1, 48'd3400001);     // pivot times out: lost
    send_beat(OP_SAMPLE, 1'b0, 1'b0, 48'd3500000);     // lost holds
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 48'd100);         // clock runs backwards
    send_beat(OP_RESET,  1'b0, 1'b0, 48'd200);
    send_beat(OP_SAMPLE, 1'b1, 1'b1, 48'd0);           // junction right after reset
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 48'd1);
    send_beat(OP_SAMPLE, 1'b1, 1'b0, '1);              // black time saturates
    directed = beats;

    // Random beats under a series of register settings.
    for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
      settle();
      case (setting)
        0: begin
          cs = RST_CRUISE_SPD; ns = RST_NUDGE_SPD; nt = RST_INNER_TRIM;
          ps = RST_PIVOT_SPD;  rs = RST_CREEP_SPD;
          ca = 16'd120; rm = 16'd260; pt = 16'd2500;
        end
        1: begin
          cs = '0; ns = '0; nt = '0; ps = '0; rs = '0;
          ca = '0; rm = '0; pt = '0;
        end
        2: begin
          cs = '1; ns = '1; nt = '1; ps = '1; rs = '1;
          ca = '1; rm = '1; pt = '1;
        end
        3: begin
          // Trim above the nudge speed drives the inner wheel backwards.
          cs = 8'd1; ns = 8'd10; nt = 8'd255; ps = 8'd255; rs = 8'd0;
          ca = 16'd1; rm = 16'd2; pt = 16'd3;
        end
        default: begin
          cs = 8'($urandom); ns = 8'($urandom); nt = 8'($urandom);
          ps = 8'($urandom); rs = 8'($urandom);
          ca = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
          rm = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
          pt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        end
      endcase
      apply_settings(cs, ns, nt, ps, rs, ca, rm, pt);
      // The last setting runs with no idling on either side.
      random_beats(BEATS_PER_SETTING, setting != NUM_SETTINGS - 1);
    end
    settle();

    $display("Sent %0d sensor beats (%0d directed) under %0d register settings, extremes",
             beats, directed, NUM_SETTINGS);
    $display("included; %0d drive results were compared field by field.", checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
